FILE: rtl/krlb_pkg.sv
`timescale 1ns / 1ps

package krlb_pkg;

   localparam int KNOB_W  = 8;
   localparam int COUNT_W = 10;

   localparam logic [COUNT_W-1:0] COUNT_MAX = 10'd1023;

   // Register indexes on the configuration port.
   localparam logic [1:0] REG_MANUAL_ENABLE  = 2'd0;
   localparam logic [1:0] REG_LOW_THRESHOLD  = 2'd1;
   localparam logic [1:0] REG_HIGH_THRESHOLD = 2'd2;

   localparam logic [KNOB_W-1:0] LOW_THRESHOLD_RESET  = 8'd20;
   localparam logic [KNOB_W-1:0] HIGH_THRESHOLD_RESET = 8'd245;

   // Channel classes decided by the front end.
   localparam logic [1:0] CLS_OFF   = 2'd0;
   localparam logic [1:0] CLS_ON    = 2'd1;
   localparam logic [1:0] CLS_TIMED = 2'd2;

   // Blink half-period in milliseconds, indexed by the knob's upper five bits.
   localparam logic [COUNT_W-1:0] PERIOD_TABLE [32] = '{
      10'd1000, 10'd1000, 10'd1000, 10'd500, 10'd333, 10'd250, 10'd200, 10'd166,
      10'd142,  10'd125,  10'd111,  10'd100, 10'd90,  10'd83,  10'd76,  10'd71,
      10'd66,   10'd62,   10'd58,   10'd55,  10'd52,  10'd50,  10'd47,  10'd45,
      10'd43,   10'd41,   10'd40,   10'd38,  10'd37,  10'd35,  10'd34,  10'd33
   };

   typedef struct packed {
      logic               tick;
      logic [1:0]         uv_cls;
      logic [COUNT_W-1:0] uv_period;
      logic [1:0]         white_cls;
      logic [COUNT_W-1:0] white_period;
      logic [KNOB_W-1:0]  dim;
      logic               left_held;
      logic               right_held;
   } item_type;

   typedef struct packed {
      logic               manual_enable;
      logic [KNOB_W-1:0]  low_threshold;
      logic [KNOB_W-1:0]  high_threshold;
   } cfg_type;

endpackage

FILE: rtl/krlb_front.sv
`timescale 1ns / 1ps

module krlb_front (
   input  krlb_pkg::cfg_type         cfg,
   input  logic                      tick,
   input  logic [krlb_pkg::KNOB_W-1:0] uv_rate_knob,
   input  logic [krlb_pkg::KNOB_W-1:0] white_rate_knob,
   input  logic [krlb_pkg::KNOB_W-1:0] white_dim_knob,
   input  logic                      left_held,
   input  logic                      right_held,
   output krlb_pkg::item_type        item
);
   import krlb_pkg::*;

   function automatic logic [1:0] classify(input logic [KNOB_W-1:0] knob,
                                           input cfg_type c);
      logic [1:0] cls;
      if (knob < c.low_threshold) begin
         cls = CLS_OFF;
      end else if (knob > c.high_threshold) begin
         cls = CLS_ON;
      end else begin
         cls = CLS_TIMED;
      end
      return cls;
   endfunction

   always_comb begin
      item.tick         = tick;
      item.uv_cls       = classify(uv_rate_knob, cfg);
      item.uv_period    = PERIOD_TABLE[uv_rate_knob[KNOB_W-1:3]];
      item.white_cls    = classify(white_rate_knob, cfg);
      item.white_period = PERIOD_TABLE[white_rate_knob[KNOB_W-1:3]];
      item.dim          = white_dim_knob;
      item.left_held    = left_held;
      item.right_held   = right_held;
   end

endmodule

FILE: rtl/krlb_queue.sv
`timescale 1ns / 1ps

module krlb_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  krlb_pkg::item_type push_item,
   output logic               full,
   input  logic               pop,
   output logic               head_valid,
   output krlb_pkg::item_type head_item
);
   import krlb_pkg::*;

   item_type   entries_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop;

   assign full       = (count_ff == 2'd2);
   assign head_valid = (count_ff != 2'd0);
   assign head_item  = entries_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

FILE: rtl/krlb_back.sv
`timescale 1ns / 1ps

module krlb_back (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        manual_enable,
   input  logic                        head_valid,
   input  krlb_pkg::item_type          head_item,
   output logic                        pop,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic                        rsp_uv_on,
   output logic [krlb_pkg::KNOB_W-1:0] rsp_left_duty,
   output logic [krlb_pkg::KNOB_W-1:0] rsp_right_duty
);
   import krlb_pkg::*;

   logic               uv_level_ff, uv_level_in;
   logic [KNOB_W-1:0]  left_level_ff, left_level_in;
   logic [KNOB_W-1:0]  right_level_ff, right_level_in;
   logic               white_phase_ff, white_phase_in;
   logic [COUNT_W-1:0] uv_count_ff, uv_count_in;
   logic [COUNT_W-1:0] white_count_ff, white_count_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_uv_on_ff;
   logic [KNOB_W-1:0]  rsp_left_duty_ff;
   logic [KNOB_W-1:0]  rsp_right_duty_ff;

   assign pop            = head_valid && (!rsp_valid_ff || rsp_ready);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_uv_on      = rsp_uv_on_ff;
   assign rsp_left_duty  = rsp_left_duty_ff;
   assign rsp_right_duty = rsp_right_duty_ff;

   always_comb begin
      uv_level_in    = uv_level_ff;
      left_level_in  = left_level_ff;
      right_level_in = right_level_ff;
      white_phase_in = white_phase_ff;
      uv_count_in    = uv_count_ff;
      white_count_in = white_count_ff;

      if (manual_enable) begin
         if (head_item.tick && uv_count_ff != COUNT_MAX) begin
            uv_count_in = uv_count_ff + 10'd1;
         end
         if (head_item.tick && white_count_ff != COUNT_MAX) begin
            white_count_in = white_count_ff + 10'd1;
         end

         case (head_item.uv_cls)
            CLS_OFF: begin
               uv_level_in = 1'b0;
            end
            CLS_ON: begin
               uv_level_in = 1'b1;
            end
            default: begin
               if (uv_count_in >= head_item.uv_period) begin
                  uv_count_in = '0;
                  uv_level_in = ~uv_level_ff;
               end
            end
         endcase

         if (head_item.left_held) begin
            left_level_in = head_item.dim;
         end
         if (head_item.right_held) begin
            right_level_in = head_item.dim;
         end

         case (head_item.white_cls)
            CLS_OFF: begin
               if (!head_item.left_held) begin
                  left_level_in = '0;
               end
               if (!head_item.right_held) begin
                  right_level_in = '0;
               end
            end
            CLS_ON: begin
               left_level_in  = head_item.dim;
               right_level_in = head_item.dim;
            end
            default: begin
               if (white_count_in >= head_item.white_period) begin
                  white_count_in = '0;
                  if (white_phase_ff) begin
                     if (!head_item.left_held) begin
                        left_level_in = '0;
                     end
                     if (!head_item.right_held) begin
                        right_level_in = '0;
                     end
                  end else begin
                     left_level_in  = head_item.dim;
                     right_level_in = head_item.dim;
                  end
                  white_phase_in = ~white_phase_ff;
               end
            end
         endcase
      end

      if (pop) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         uv_level_ff    <= 1'b0;
         left_level_ff  <= '0;
         right_level_ff <= '0;
         white_phase_ff <= 1'b0;
         uv_count_ff    <= '0;
         white_count_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (pop) begin
            uv_level_ff    <= uv_level_in;
            left_level_ff  <= left_level_in;
            right_level_ff <= right_level_in;
            white_phase_ff <= white_phase_in;
            uv_count_ff    <= uv_count_in;
            white_count_ff <= white_count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_uv_on_ff      <= uv_level_in;
         rsp_left_duty_ff  <= left_level_in;
         rsp_right_duty_ff <= right_level_in;
      end
   end

endmodule

FILE: rtl/knob_rate_led_blinker.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake              Payload
// req       in         req_valid / req_ready  tick, three knob samples, two button levels
// rsp       out        rsp_valid / rsp_ready  uv_on, left_duty, right_duty
// csr       in         csr_we                 csr_index selects, csr_wdata carries the value
//
// Each transaction is classified on acceptance and lands in a two-entry queue.
// The back end retires one queued transaction per cycle into the result register
// unless rsp stalls; a transaction passes a queue entry, then the result register.
// req_ready drops only when the queue is full; rsp stalls hold the result register.
// Reset is synchronous and clears all blink state and restores the register defaults.

module knob_rate_led_blinker (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic                        req_tick,
   input  logic [krlb_pkg::KNOB_W-1:0] req_uv_rate_knob,
   input  logic [krlb_pkg::KNOB_W-1:0] req_white_rate_knob,
   input  logic [krlb_pkg::KNOB_W-1:0] req_white_dim_knob,
   input  logic                        req_left_held,
   input  logic                        req_right_held,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic                        rsp_uv_on,
   output logic [krlb_pkg::KNOB_W-1:0] rsp_left_duty,
   output logic [krlb_pkg::KNOB_W-1:0] rsp_right_duty,
   input  logic                        csr_we,
   input  logic [1:0]                  csr_index,
   input  logic [krlb_pkg::KNOB_W-1:0] csr_wdata
);
   import krlb_pkg::*;

   cfg_type  cfg_ff;
   item_type front_item;
   item_type head_item;
   logic     queue_full;
   logic     head_valid;
   logic     pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.manual_enable  <= 1'b0;
         cfg_ff.low_threshold  <= LOW_THRESHOLD_RESET;
         cfg_ff.high_threshold <= HIGH_THRESHOLD_RESET;
      end else if (csr_we) begin
         case (csr_index)
            REG_MANUAL_ENABLE:  cfg_ff.manual_enable  <= csr_wdata[0];
            REG_LOW_THRESHOLD:  cfg_ff.low_threshold  <= csr_wdata;
            REG_HIGH_THRESHOLD: cfg_ff.high_threshold <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign req_ready = !queue_full;

   krlb_front u_front (
      .cfg             (cfg_ff),
      .tick            (req_tick),
      .uv_rate_knob    (req_uv_rate_knob),
      .white_rate_knob (req_white_rate_knob),
      .white_dim_knob  (req_white_dim_knob),
      .left_held       (req_left_held),
      .right_held      (req_right_held),
      .item            (front_item)
   );

   krlb_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (req_valid),
      .push_item  (front_item),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_item  (head_item)
   );

   krlb_back u_back (
      .clock          (clock),
      .reset          (reset),
      .manual_enable  (cfg_ff.manual_enable),
      .head_valid     (head_valid),
      .head_item      (head_item),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_uv_on      (rsp_uv_on),
      .rsp_left_duty  (rsp_left_duty),
      .rsp_right_duty (rsp_right_duty)
   );

endmodule
